// File: rtl/sirt_pkg.sv
`default_nettype none

package sirt_pkg;

    localparam int NUM_W           = 32;
    localparam int CHAR_W          = 8;
    localparam int LEN_W           = 6;
    localparam int LANES           = 32;
    localparam int DIGIT_W         = 5;
    localparam int CNT_W           = 5;
    localparam int STEP_W          = 4;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int SYMS_PER_REG    = 8;
    localparam int MAX_SYMBOLS_DEF = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 3'd1;

    localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;

    localparam logic [LEN_W-1:0] MIN_RADIX = 6'd2;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE   = 4'd0;
    localparam step_t STEP_LEN    = 4'd1;
    localparam step_t STEP_SCAN   = 4'd2;
    localparam step_t STEP_VERD   = 4'd3;
    localparam step_t STEP_CONV   = 4'd4;
    localparam step_t STEP_SIGN   = 4'd5;
    localparam step_t STEP_DIGIT  = 4'd6;
    localparam step_t STEP_NL     = 4'd7;
    localparam step_t STEP_ERR    = 4'd8;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_SCAN,
        OP_CONV,
        OP_SIGN,
        OP_DIGIT,
        OP_NL,
        OP_ERR
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_ITEM,
        C_LEN_BAD,
        C_SCAN_MORE,
        C_BAD,
        C_CONV_MORE,
        C_DIGIT_MORE
    } cond_t;

    typedef struct packed {
        op_t   op;
        logic  hold;
        cond_t cond;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } lane_ctrl_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        case (step)
            STEP_IDLE:  w = '{op: OP_LOAD,  hold: 1'b0, cond: C_NO_ITEM,    target: STEP_IDLE};
            STEP_LEN:   w = '{op: OP_CLEAR, hold: 1'b0, cond: C_LEN_BAD,    target: STEP_ERR};
            STEP_SCAN:  w = '{op: OP_SCAN,  hold: 1'b0, cond: C_SCAN_MORE,  target: STEP_SCAN};
            STEP_VERD:  w = '{op: OP_CLEAR, hold: 1'b0, cond: C_BAD,        target: STEP_ERR};
            STEP_CONV:  w = '{op: OP_CONV,  hold: 1'b0, cond: C_CONV_MORE,  target: STEP_CONV};
            STEP_SIGN:  w = '{op: OP_SIGN,  hold: 1'b1, cond: C_NEVER,      target: STEP_IDLE};
            STEP_DIGIT: w = '{op: OP_DIGIT, hold: 1'b1, cond: C_DIGIT_MORE, target: STEP_DIGIT};
            STEP_NL:    w = '{op: OP_NL,    hold: 1'b1, cond: C_ALWAYS,     target: STEP_IDLE};
            STEP_ERR:   w = '{op: OP_ERR,   hold: 1'b1, cond: C_ALWAYS,     target: STEP_IDLE};
            default:    w = '{op: OP_NONE,  hold: 1'b0, cond: C_ALWAYS,     target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sirt_radix_lanes.sv
`default_nettype none

module sirt_radix_lanes import sirt_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lane_ctrl_t         ctrl,
    input  wire logic               bit_in,
    input  wire logic [LEN_W-1:0]   radix,
    input  wire logic [DIGIT_W-1:0] rd_idx,
    output logic      [DIGIT_W-1:0] rd_digit,
    output logic      [LEN_W-1:0]   digit_count
);

    logic [DIGIT_W-1:0] lane_reg  [LANES];
    logic [DIGIT_W-1:0] lane_next [LANES];
    logic [LANES-1:0]   gen;
    logic [LANES-1:0]   prop;
    logic [LANES-1:0]   carry;
    logic [LANES:0]     csum;
    logic [LEN_W-1:0]   count_reg;
    logic [LEN_W-1:0]   count_next;
    logic               top_carry;

    // each lane doubles its digit and adds the carry from below; a lane
    // generates a carry if 2d >= radix and passes one on if 2d+1 == radix
    always_comb begin
        logic [LEN_W-1:0] sum6;
        for (int k = 0; k < LANES; k++) begin
            gen[k]  = ({lane_reg[k], 1'b0} >= radix);
            prop[k] = !gen[k] && ({lane_reg[k], 1'b1} == radix);
        end
        // carry chain resolved by one adder
        csum  = {1'b0, gen | prop} + {1'b0, gen} + {{LANES{1'b0}}, bit_in};
        carry = csum[LANES-1:0] ^ prop;
        for (int k = 0; k < LANES; k++) begin
            sum6 = {lane_reg[k], carry[k]};
            if (gen[k] || (prop[k] && carry[k])) begin
                sum6 = sum6 - radix;
            end
            lane_next[k] = sum6[DIGIT_W-1:0];
        end
    end

    // digits in use grow by one when a carry reaches the first unused lane
    always_comb begin
        top_carry = 1'b0;
        if (count_reg < LEN_W'(LANES)) begin
            top_carry = carry[count_reg[DIGIT_W-1:0]];
        end
        count_next = count_reg + {{(LEN_W-1){1'b0}}, top_carry};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            for (int k = 0; k < LANES; k++) begin
                lane_reg[k] <= '0;
            end
        end else if (ctrl.shift) begin
            for (int k = 0; k < LANES; k++) begin
                lane_reg[k] <= lane_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= LEN_W'(1);
        end else if (ctrl.clear) begin
            count_reg <= LEN_W'(1);
        end else if (ctrl.shift) begin
            count_reg <= count_next;
        end
    end

    assign rd_digit    = lane_reg[rd_idx];
    assign digit_count = count_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) && (count_reg <= LEN_W'(LANES)))
        else $error("digit count out of range");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.shift && !ctrl.clear |=> (count_reg - $past(count_reg)) <= LEN_W'(1))
        else $error("digit count jumped");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.shift && !ctrl.clear && (radix >= MIN_RADIX) |-> !csum[LANES])
        else $error("carry left the top lane");

endmodule

`default_nettype wire

// File: rtl/signed_integer_to_radix_text.sv
`default_nettype none

// the first character follows the input transfer after the length check, symbol checks,
// verdict, 32 lane-update steps and the sign step; without a minus sign it is a digit
// one number at a time: a new number is taken only once the last character of the
// previous result is registered; pace set by the 32-step radix lane update and one
// character per cycle out when not stalled; an invalid base gives a single result
// reset: synchronous, active low; clears config registers (base invalid) and the sequencer

module signed_integer_to_radix_text import sirt_pkg::*; #(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // number
    input  wire logic [NUM_W-1:0]      s_tdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // character
    output logic      [CHAR_W-1:0]     m_tdata,
    // bad_base
    output logic                       m_tuser,
    output logic                       m_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SYM_IDX_W = $clog2(MAX_SYMBOLS);

    logic [LEN_W-1:0]     base_len_reg;
    logic [CHAR_W-1:0]    sym_reg [MAX_SYMBOLS];

    step_t                step_reg, step_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 bad_reg, bad_next;
    logic                 neg_reg, neg_next;
    logic [NUM_W-1:0]     mag_reg, mag_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 bad_out_reg, bad_out_next;
    logic                 last_reg, last_next;

    ucode_t               ucode;
    logic                 out_free;
    logic                 emit_want;
    logic                 emit;
    logic                 stall;
    logic                 accept;
    logic                 cond_hit;
    logic                 len_bad;
    logic [SYM_IDX_W-1:0] rd_idx;
    logic [CHAR_W-1:0]    sym_cur;
    logic                 dup_hit;
    logic                 sym_bad;
    lane_ctrl_t           lane_ctrl;
    logic [DIGIT_W-1:0]   lane_digit;
    logic [LEN_W-1:0]     digit_count;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_len_reg <= '0;
        end else if (cfg_we && cfg_index == REG_BASE_LENGTH) begin
            base_len_reg <= cfg_data[LEN_W-1:0];
        end
    end

    for (genvar k = 0; k < MAX_SYMBOLS; k++) begin : g_sym
        localparam logic [CFG_IDX_W-1:0] SymReg = REG_SYMBOLS_LOW + CFG_IDX_W'(k / SYMS_PER_REG);
        localparam int SymLsb = CHAR_W * (k % SYMS_PER_REG);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sym_reg[k] <= '0;
            end else if (cfg_we && cfg_index == SymReg) begin
                sym_reg[k] <= cfg_data[SymLsb +: CHAR_W];
            end
        end
    end

    // one symbol read port, shared by the check and the digit output
    always_comb begin
        if (ucode.op == OP_SCAN) begin
            rd_idx = cnt_reg[SYM_IDX_W-1:0];
        end else begin
            rd_idx = lane_digit[SYM_IDX_W-1:0];
        end
        sym_cur = CHAR_NUL;
        if (int'(rd_idx) < MAX_SYMBOLS) begin
            sym_cur = sym_reg[rd_idx];
        end
    end

    // symbol under check against every later symbol in use
    always_comb begin
        dup_hit = 1'b0;
        for (int j = 0; j < MAX_SYMBOLS; j++) begin
            if (j > int'(cnt_reg) && j < int'(base_len_reg) && sym_reg[j] == sym_cur) begin
                dup_hit = 1'b1;
            end
        end
        sym_bad = dup_hit || sym_cur == CHAR_PLUS || sym_cur == CHAR_MINUS
                  || sym_cur == CHAR_NUL;
    end

    assign len_bad = (base_len_reg < MIN_RADIX) || (base_len_reg > LEN_W'(MAX_SYMBOLS));

    // sequencer
    always_comb begin
        ucode    = ucode_rom(step_reg);
        out_free = !m_tvalid_reg || m_tready;
        unique case (ucode.op)
            OP_SIGN:                   emit_want = neg_reg;
            OP_DIGIT, OP_NL, OP_ERR:   emit_want = 1'b1;
            default:                   emit_want = 1'b0;
        endcase
        stall    = ucode.hold && emit_want && !out_free;
        emit     = emit_want && out_free;
        s_tready = (ucode.op == OP_LOAD);
        accept   = s_tvalid && s_tready;

        unique case (ucode.cond)
            C_NEVER:      cond_hit = 1'b0;
            C_ALWAYS:     cond_hit = 1'b1;
            C_NO_ITEM:    cond_hit = !s_tvalid;
            C_LEN_BAD:    cond_hit = len_bad;
            C_SCAN_MORE:  cond_hit = {1'b0, cnt_reg} != (base_len_reg - LEN_W'(1));
            C_BAD:        cond_hit = bad_reg;
            C_CONV_MORE:  cond_hit = cnt_reg != CNT_W'(LANES - 1);
            C_DIGIT_MORE: cond_hit = cnt_reg != '0;
            default:      cond_hit = 1'b0;
        endcase

        if (stall) begin
            step_next = step_reg;
        end else if (cond_hit) begin
            step_next = ucode.target;
        end else begin
            step_next = step_reg + STEP_W'(1);
        end
    end

    // datapath actions
    always_comb begin
        cnt_next        = cnt_reg;
        bad_next        = bad_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        char_next       = char_reg;
        bad_out_next    = bad_out_reg;
        last_next       = last_reg;
        lane_ctrl.clear = 1'b0;
        lane_ctrl.shift = 1'b0;

        unique case (ucode.op)
            OP_LOAD: begin
                if (accept) begin
                    neg_next        = s_tdata[NUM_W-1];
                    mag_next        = s_tdata[NUM_W-1] ? (NUM_W'(0) - s_tdata) : s_tdata;
                    lane_ctrl.clear = 1'b1;
                end
            end
            OP_CLEAR: begin
                cnt_next = '0;
                if (step_reg == STEP_LEN) begin
                    bad_next = 1'b0;
                end
            end
            OP_SCAN: begin
                bad_next = bad_reg || sym_bad;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            OP_CONV: begin
                lane_ctrl.shift = 1'b1;
                mag_next        = {mag_reg[NUM_W-2:0], 1'b0};
                cnt_next        = cnt_reg + CNT_W'(1);
            end
            OP_SIGN: begin
                if (!stall) begin
                    cnt_next = CNT_W'(digit_count - LEN_W'(1));
                end
                if (emit) begin
                    char_next    = CHAR_MINUS;
                    bad_out_next = 1'b0;
                    last_next    = 1'b0;
                end
            end
            OP_DIGIT: begin
                if (emit) begin
                    char_next    = sym_cur;
                    bad_out_next = 1'b0;
                    last_next    = 1'b0;
                    cnt_next     = cnt_reg - CNT_W'(1);
                end
            end
            OP_NL: begin
                if (emit) begin
                    char_next    = CHAR_NEWLINE;
                    bad_out_next = 1'b0;
                    last_next    = 1'b1;
                end
            end
            OP_ERR: begin
                if (emit) begin
                    char_next    = CHAR_NUL;
                    bad_out_next = 1'b1;
                    last_next    = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= STEP_IDLE;
            cnt_reg      <= '0;
            bad_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            cnt_reg      <= cnt_next;
            bad_reg      <= bad_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
        char_reg    <= char_next;
        bad_out_reg <= bad_out_next;
        last_reg    <= last_next;
    end

    sirt_radix_lanes u_lanes (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (lane_ctrl),
        .bit_in      (mag_reg[NUM_W-1]),
        .radix       (base_len_reg),
        .rd_idx      (cnt_reg),
        .rd_digit    (lane_digit),
        .digit_count (digit_count)
    );

    assign m_tdata  = char_reg;
    assign m_tuser  = bad_out_reg;
    assign m_tlast  = last_reg;
    assign m_tvalid = m_tvalid_reg;

    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == CHAR_NUL))
        else $error("error result carries a character");

    a_last_newline: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser && m_tlast |-> (m_tdata == CHAR_NEWLINE))
        else $error("final character is not a newline");

    a_digit_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == STEP_DIGIT) |-> ({1'b0, cnt_reg} < digit_count))
        else $error("digit index beyond digits in use");

    a_conv_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == STEP_CONV) |-> !len_bad && !bad_reg)
        else $error("conversion started with an invalid base");

endmodule

`default_nettype wire
